FILE: rtl/three_stacks_in_one_array_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three-stacks block.
// ---------------------------------------------------------------------------
`ifndef THREE_STACKS_IN_ONE_ARRAY_ASSERT_SVH
`define THREE_STACKS_IN_ONE_ARRAY_ASSERT_SVH

// Check a property on every rising edge of clk outside of reset.
`define TSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define TSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tsa_pkg.sv
// ---------------------------------------------------------------------------
// tsa_pkg
// Shared widths, operation codes and status codes of the stack block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsa_pkg;

    // Field widths of a request and of a result.
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int SEL_W  = 2;
    localparam int ST_W   = 2;

    // Default geometry of the shared storage.
    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_STACKS_DEF  = 3;

    // Operation codes; any other code behaves as a peek.
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Value returned by a pop or peek of an empty stack.
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

endpackage

FILE: rtl/tsa_ram.sv
// ---------------------------------------------------------------------------
// tsa_ram
// Single-port storage array with a registered read, one access per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_ram
    import tsa_pkg::*;
#(
    parameter int DEPTH  = STACK_DEPTH_DEF * NUM_STACKS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic [ADDR_W-1:0] addr,
    input  logic              we,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/three_stacks_in_one_array.sv
// ---------------------------------------------------------------------------
// three_stacks_in_one_array
// Several LIFO stacks sharing one storage memory in equal partitions.
// ---------------------------------------------------------------------------
// Requests enter on the s_axis channel: tdata carries the value to push and
// tuser carries the operation (push, pop, peek) and the stack number.
// Every request gives exactly one result on the m_axis channel: tdata holds
// the top value (-1 for an empty stack, 0 for a push) and tuser the status
// (ok, empty, or full with the push dropped).
// A request is accepted in any cycle in which the pipeline can move, so the
// block sustains one request per cycle. After acceptance the result passes
// through the read stage, with its registered memory read, and then the
// output register. The per-stack entry counts sit in flip-flops and are
// updated at acceptance, so a request always sees the effect of the one
// before it, and the memory write of a push lands before any later read.
// Reset empties every stack by clearing the counts; memory contents are not
// cleared, as an entry is read only after it has been pushed.
// When the receiver holds m_axis_tready low, the output register and the
// memory read stage fill up and s_axis_tready drops until the output drains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_stacks_in_one_array
    import tsa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NUM_STACKS  = NUM_STACKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] push_value
    input  logic [3:0]        s_axis_tuser,   // [1:0] req_type, [3:2] stack_sel

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] read_value
    output logic [ST_W-1:0]   m_axis_tuser    // [1:0] status
);

    localparam int TOTAL  = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    // Request fields.
    logic [OP_W-1:0]   req_type;
    logic [SEL_W-1:0]  stack_sel;
    logic [DATA_W-1:0] push_value;

    assign req_type   = s_axis_tuser[OP_W-1:0];
    assign stack_sel  = s_axis_tuser[OP_W+SEL_W-1:OP_W];
    assign push_value = s_axis_tdata;

    // Entry counts, one per stack.
    logic [CNT_W-1:0] count_reg  [NUM_STACKS];
    logic [CNT_W-1:0] count_next [NUM_STACKS];

    // Pipeline: read stage and output register.
    logic              s1_valid_reg;
    logic              s1_from_mem_reg;
    logic [DATA_W-1:0] s1_value_reg;
    logic [ST_W-1:0]   s1_status_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [ST_W-1:0]   out_status_reg;

    logic              in_accept;
    logic              s1_move;
    logic              s1_wait_mem;
    logic              sel_ok;
    logic [CNT_W-1:0]  cur_count;
    logic [ADDR_W-1:0] base_addr;
    logic              is_push;
    logic              is_pop;
    logic              stack_full;
    logic              stack_empty;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] imm_value;
    logic [ST_W-1:0]   imm_status;

    // Handshake: the read stage drains when the output register is free.
    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // A stalled read stage that still waits for its memory data.
    assign s1_wait_mem = s1_valid_reg && s1_from_mem_reg && !s1_move;

    // Look up the addressed stack's count and partition base.
    always_comb
    begin
        sel_ok    = 1'b0;
        cur_count = '0;
        base_addr = '0;
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            if (int'(stack_sel) == s)
            begin
                sel_ok    = 1'b1;
                cur_count = count_reg[s];
                base_addr = ADDR_W'(s * STACK_DEPTH);
            end
        end
    end

    assign is_push     = (req_type == OP_PUSH);
    assign is_pop      = (req_type == OP_POP);
    assign stack_full  = !sel_ok || (cur_count >= CNT_W'(STACK_DEPTH));
    assign stack_empty = !sel_ok || (cur_count == '0);

    // Decide the memory access and the result that needs no memory data.
    always_comb
    begin
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = base_addr + ADDR_W'(cur_count);
        imm_value  = '0;
        imm_status = ST_OK;
        if (is_push)
        begin
            if (stack_full)
            begin
                imm_status = ST_FULL;
            end
            else
            begin
                mem_we = in_accept;
            end
        end
        else
        begin
            mem_addr = base_addr + ADDR_W'(cur_count - CNT_W'(1));
            if (stack_empty)
            begin
                imm_value  = EMPTY_VALUE;
                imm_status = ST_EMPTY;
            end
            else
            begin
                mem_re = in_accept;
            end
        end
    end

    // Next counts: a push adds an entry, a pop removes one.
    always_comb
    begin
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            count_next[s] = count_reg[s];
            if (in_accept && (int'(stack_sel) == s))
            begin
                if (is_push && !stack_full)
                begin
                    count_next[s] = count_reg[s] + CNT_W'(1);
                end
                else if (is_pop && !stack_empty)
                begin
                    count_next[s] = count_reg[s] - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STACKS; s++)
            begin
                count_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < NUM_STACKS; s++)
            begin
                count_reg[s] <= count_next[s];
            end
        end
    end

    // Shared storage.
    tsa_ram #(
        .DEPTH  (TOTAL),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (push_value),
        .re    (mem_re),
        .rdata (mem_rdata)
    );

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_from_mem_reg <= mem_re;
            s1_value_reg    <= imm_value;
            s1_status_reg   <= imm_status;
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_value_reg  <= s1_from_mem_reg ? mem_rdata : s1_value_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    // Checks on the stage logic and the count bookkeeping.
    `include "three_stacks_in_one_array_assert.svh"

    `TSA_ASSERT(a_read_data_held, s1_wait_mem |=> $stable(mem_rdata), "read data moved in a stall")
    `TSA_ASSERT(a_accept_fills_s1, in_accept |=> s1_valid_reg, "accept did not fill read stage")
    `TSA_ASSERT(a_push_has_room, mem_we |-> (cur_count < CNT_W'(STACK_DEPTH)), "push overflow")
    `TSA_ASSERT_ALWAYS(a_read_nonempty, mem_re |-> (cur_count != '0), "read of an empty stack")

endmodule

FILE: tb/stack_result_checker.sv
// ---------------------------------------------------------------------------
// Result checker for the three-stack block
// Watches both stream channels and keeps its own copy of the stacks. Each
// accepted request is turned into an expected result, and each accepted
// result is compared against the oldest one still waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_result_checker
    import tsa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NUM_STACKS  = NUM_STACKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] push_value
    input  logic [3:0]        s_axis_tuser,   // [1:0] req_type, [3:2] stack_sel

    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata,   // [31:0] read_value
    input  logic [ST_W-1:0]   m_axis_tuser,   // [1:0] status

    output int unsigned       fail_count,
    output int unsigned       results_due,
    output int unsigned       results_checked,
    output int unsigned       full_seen,
    output int unsigned       empty_seen
);

    // One expected result: the value read and the status.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ST_W-1:0]   status;
    } stack_result_t;

    // Shadow copy of the shared storage and of the per-stack entry counts.
    logic [DATA_W-1:0] shadow_store [NUM_STACKS*STACK_DEPTH];
    int unsigned       shadow_used  [NUM_STACKS];

    stack_result_t     awaited_results [$];

    initial
    begin
        fail_count      = 0;
        results_due     = 0;
        results_checked = 0;
        full_seen       = 0;
        empty_seen      = 0;
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            shadow_used[s] = 0;
        end
    end

    // Apply one request to the shadow stacks and return what the block must answer.
    function automatic stack_result_t apply_request(input logic [OP_W-1:0] op,
                                                    input logic [SEL_W-1:0] sel,
                                                    input logic [DATA_W-1:0] val);
        stack_result_t res;
        res.value  = '0;
        res.status = ST_OK;
        if (op == OP_PUSH)
        begin
            if (sel >= NUM_STACKS || shadow_used[sel] >= STACK_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                shadow_store[sel*STACK_DEPTH + shadow_used[sel]] = val;
                shadow_used[sel] = shadow_used[sel] + 1;
            end
        end
        else if (sel >= NUM_STACKS || shadow_used[sel] == 0)
        begin
            // Any code other than push or pop leaves the stack as it is.
            res.value  = EMPTY_VALUE;
            res.status = ST_EMPTY;
        end
        else
        begin
            res.value = shadow_store[sel*STACK_DEPTH + shadow_used[sel] - 1];
            if (op == OP_POP)
            begin
                shadow_used[sel] = shadow_used[sel] - 1;
            end
        end
        return res;
    endfunction

    // Predict on each accepted request, then compare each accepted result.
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_results.push_back(apply_request(s_axis_tuser[1:0],
                                                        s_axis_tuser[3:2],
                                                        s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no request waiting: read_value %h status %0d",
                           m_axis_tdata, m_axis_tuser);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked = results_checked + 1;
                    if (want.status == ST_FULL)
                        full_seen = full_seen + 1;
                    if (want.status == ST_EMPTY)
                        empty_seen = empty_seen + 1;
                    if (m_axis_tdata !== want.value)
                    begin
                        $error("read_value mismatch: expected %h, actual %h",
                               want.value, m_axis_tdata);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_axis_tuser);
                        fail_count = fail_count + 1;
                    end
                end
            end
            results_due = awaited_results.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// Testbench top for three_stacks_in_one_array
// Drives push, pop and peek requests into the block with random gaps on the
// request side and random back-pressure on the result side. A directed
// opening covers empty stacks, the missing fourth stack, the spare opcode
// and extreme values; bursts of pushes and pops then fill and drain stacks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tsa_pkg::*;

    // The unused opcode behaves as a peek; the unused selector names no stack.
    localparam logic [OP_W-1:0]  OP_SPARE     = 2'd3;
    localparam logic [SEL_W-1:0] SEL_NO_STACK = 2'd3;

    localparam int RANDOM_REQUESTS = 1050;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 12;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // [31:0] push_value
    logic [3:0]        s_axis_tuser;   // [1:0] req_type, [3:2] stack_sel
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;   // [31:0] read_value
    logic [ST_W-1:0]   m_axis_tuser;   // [1:0] status

    int unsigned fail_count;
    int unsigned results_due;
    int unsigned results_checked;
    int unsigned full_seen;
    int unsigned empty_seen;

    int unsigned cycle_count;
    int unsigned requests_sent;
    int unsigned pushes_sent;
    int unsigned pops_sent;
    int unsigned peeks_sent;
    int unsigned spare_ops_sent;
    int unsigned no_stack_sent;
    bit          steady;          // both sides run without gaps while set
    int unsigned ready_hold;
    bit          ready_level;

    three_stacks_in_one_array DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    stack_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .results_due     (results_due),
        .results_checked (results_checked),
        .full_seen       (full_seen),
        .empty_seen      (empty_seen)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Push value: mostly random, sometimes an extreme.
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) != 0)
            return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    // Result side back-pressure, changed at the falling edge.
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_level = steady || ($urandom_range(0, 99) < 70);
            ready_hold  = ready_level ? $urandom_range(1, 8) : pick_gap() + 1;
        end
        ready_hold = ready_hold - 1;
        m_axis_tready <= ready_level;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                            input logic [DATA_W-1:0] val);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= {sel, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent = requests_sent + 1;
        if (sel == SEL_NO_STACK)
            no_stack_sent = no_stack_sent + 1;
        case (op)
            OP_PUSH: pushes_sent = pushes_sent + 1;
            OP_POP:  pops_sent = pops_sent + 1;
            OP_PEEK: peeks_sent = peeks_sent + 1;
            default:
            begin
                peeks_sent     = peeks_sent + 1;
                spare_ops_sent = spare_ops_sent + 1;
            end
        endcase
    endtask

    // Hold off new requests until every result is back.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [SEL_W-1:0] sel;
        logic [OP_W-1:0]  op;
        int unsigned      kind;
        int unsigned      burst;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        steady         = 1'b0;
        ready_hold     = 0;
        ready_level    = 1'b0;
        cycle_count    = 0;
        requests_sent  = 0;
        pushes_sent    = 0;
        pops_sent      = 0;
        peeks_sent     = 0;
        spare_ops_sent = 0;
        no_stack_sent  = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty stacks, the missing stack and the spare opcode.
        send_req(OP_POP,   2'd0,         32'h1234_5678);
        send_req(OP_PEEK,  2'd1,         32'h0);
        send_req(OP_SPARE, 2'd2,         32'h0);
        send_req(OP_PUSH,  SEL_NO_STACK, 32'hDEAD_BEEF);
        send_req(OP_POP,   SEL_NO_STACK, 32'h0);
        send_req(OP_PEEK,  SEL_NO_STACK, 32'h0);
        send_req(OP_SPARE, SEL_NO_STACK, 32'h0);

        // Extreme values through each stack.
        send_req(OP_PUSH,  2'd0, 32'h7FFF_FFFF);
        send_req(OP_PUSH,  2'd0, 32'h8000_0000);
        send_req(OP_PUSH,  2'd1, 32'hFFFF_FFFF);
        send_req(OP_PUSH,  2'd2, 32'h0000_0000);
        send_req(OP_PUSH,  2'd2, 32'hAAAA_AAAA);
        send_req(OP_PUSH,  2'd2, 32'h5555_5555);
        send_req(OP_PEEK,  2'd0, 32'h0);
        send_req(OP_SPARE, 2'd0, 32'h0);
        send_req(OP_POP,   2'd0, 32'h0);
        send_req(OP_POP,   2'd0, 32'h0);
        send_req(OP_POP,   2'd0, 32'h0);
        send_req(OP_POP,   2'd1, 32'h0);
        send_req(OP_PEEK,  2'd2, 32'h0);
        send_req(OP_POP,   2'd2, 32'h0);
        send_req(OP_POP,   2'd2, 32'h0);
        send_req(OP_POP,   2'd2, 32'h0);
        send_req(OP_POP,   2'd2, 32'h0);
        wait_drained();

        // Random part: push bursts long enough to fill a stack, pop bursts
        // that run it dry, mixed traffic, and a little noise.
        while (requests_sent < RANDOM_REQUESTS + 24)
        begin
            steady = ($urandom_range(0, 6) == 0);
            sel    = SEL_W'($urandom_range(0, NUM_STACKS_DEF - 1));
            kind   = $urandom_range(0, 99);
            if (kind < 35)
            begin
                burst = $urandom_range(1, STACK_DEPTH_DEF + 4);
                repeat (burst) send_req(OP_PUSH, sel, pick_value());
            end
            else if (kind < 65)
            begin
                burst = $urandom_range(1, STACK_DEPTH_DEF + 2);
                repeat (burst)
                begin
                    op = ($urandom_range(0, 4) == 0) ? OP_PEEK : OP_POP;
                    send_req(op, sel, $urandom());
                end
            end
            else if (kind < 90)
            begin
                burst = $urandom_range(1, 12);
                repeat (burst)
                begin
                    op  = OP_W'($urandom_range(0, 2));
                    sel = SEL_W'($urandom_range(0, NUM_STACKS_DEF - 1));
                    send_req(op, sel, pick_value());
                end
            end
            else
            begin
                burst = $urandom_range(1, 4);
                repeat (burst)
                begin
                    op  = OP_W'($urandom_range(0, 3));
                    sel = SEL_W'($urandom_range(0, 3));
                    send_req(op, sel, $urandom());
                end
            end
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
        steady = 1'b0;

        // Let the pipeline empty, then keep watching for stray results.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d requests (%0d push, %0d pop, %0d peek, %0d odd op, %0d bad stack).",
                 requests_sent, pushes_sent, pops_sent, peeks_sent, spare_ops_sent,
                 no_stack_sent);
        $display("Checked %0d results, %0d dropped pushes on full stacks, %0d empty reads.",
                 results_checked, full_seen, empty_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
